/* src/rwla_pkg.sv */
// ----------------------------------------------------------------------------
// Reader/writer lock arbiter package
// Shared widths, limits and command codes of the lock arbiter.
// ----------------------------------------------------------------------------
package rwla_pkg;

    localparam int MAX_REQUESTERS = 64;
    localparam int RING_DEPTH     = 64;
    localparam int ID_W           = 6;
    localparam int CMD_W          = 2;
    localparam int PTR_W          = $clog2(RING_DEPTH);
    localparam int CNT_W          = 7;
    localparam int ACTIVE_MAX     = 127;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ_ACQUIRE  = 2'd0,
        CMD_WRITE_ACQUIRE = 2'd1,
        CMD_READ_RELEASE  = 2'd2,
        CMD_WRITE_RELEASE = 2'd3
    } cmd_t;

endpackage

/* src/rwla_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module rwla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/rwla_core.sv */
// ----------------------------------------------------------------------------
// Lock arbiter sequencer
// Decides each request, keeps the lock state and queue pointers, drives the
// queue memories and emits result items through an output register.
// ----------------------------------------------------------------------------
module rwla_core (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [rwla_pkg::CMD_W-1:0] s_cmd,
    input  logic [rwla_pkg::ID_W-1:0]  s_requester_id,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_granted,
    output logic [rwla_pkg::ID_W-1:0]  m_grant_id,
    output logic                      m_grant_is_write,
    output logic                      m_request_error,
    output logic                      m_last,
    output logic                      rq_wr_en,
    output logic [rwla_pkg::PTR_W-1:0] rq_wr_addr,
    output logic [rwla_pkg::ID_W-1:0]  rq_wr_data,
    output logic                      rq_rd_en,
    output logic [rwla_pkg::PTR_W-1:0] rq_rd_addr,
    input  logic [rwla_pkg::ID_W-1:0]  rq_rd_data,
    output logic                      wq_wr_en,
    output logic [rwla_pkg::PTR_W-1:0] wq_wr_addr,
    output logic [rwla_pkg::ID_W-1:0]  wq_wr_data,
    output logic                      wq_rd_en,
    output logic [rwla_pkg::PTR_W-1:0] wq_rd_addr,
    input  logic [rwla_pkg::ID_W-1:0]  wq_rd_data
);

    import rwla_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_WGRANT,
        ST_RGRANT
    } state_t;

    state_t            state_reg;
    cmd_t              cmd_reg;
    logic [ID_W-1:0]   id_reg;
    logic [PTR_W-1:0]  rq_head_reg;
    logic [CNT_W-1:0]  rq_count_reg;
    logic [PTR_W-1:0]  wq_head_reg;
    logic [CNT_W-1:0]  wq_count_reg;
    logic [CNT_W-1:0]  active_reg;
    logic              writer_active_reg;

    logic              m_valid_reg;
    logic              m_granted_reg;
    logic [ID_W-1:0]   m_grant_id_reg;
    logic              m_grant_is_write_reg;
    logic              m_request_error_reg;
    logic              m_last_reg;

    logic              out_free;
    logic              go;
    logic              read_free;
    logic              write_free;
    logic              rq_full;
    logic              wq_full;
    logic [CNT_W-1:0]  active_dec;
    logic [CNT_W-1:0]  active_sat_inc;
    logic              rq_push;
    logic              wq_push;
    logic              wq_pop_start;
    logic              rq_flush_start;

    logic              out_load;
    logic              out_granted;
    logic [ID_W-1:0]   out_id;
    logic              out_write;
    logic              out_err;
    logic              out_last;

    assign out_free   = !m_valid_reg || m_ready;
    assign go         = (state_reg == ST_DECIDE) && out_free;
    assign read_free  = !writer_active_reg && (wq_count_reg == '0) && (rq_count_reg == '0);
    assign write_free = !writer_active_reg && (active_reg == '0) && (wq_count_reg == '0);
    assign rq_full    = rq_count_reg >= CNT_W'(MAX_REQUESTERS);
    assign wq_full    = wq_count_reg >= CNT_W'(MAX_REQUESTERS);
    assign active_dec = active_reg - CNT_W'(1);
    assign active_sat_inc = (active_reg == CNT_W'(ACTIVE_MAX)) ? active_reg
                                                               : active_reg + CNT_W'(1);

    always_comb begin
        rq_push        = 1'b0;
        wq_push        = 1'b0;
        wq_pop_start   = 1'b0;
        rq_flush_start = 1'b0;
        out_load       = 1'b0;
        out_granted    = 1'b0;
        out_id         = '0;
        out_write      = 1'b0;
        out_err        = 1'b0;
        out_last       = 1'b1;
        case (state_reg)
            ST_DECIDE: begin
                out_load = go;
                case (cmd_reg)
                    CMD_READ_ACQUIRE: begin
                        if (read_free) begin
                            if (active_reg == CNT_W'(ACTIVE_MAX)) begin
                                out_err = 1'b1;
                            end else begin
                                out_granted = 1'b1;
                                out_id      = id_reg;
                            end
                        end else if (rq_full) begin
                            out_err = 1'b1;
                        end else begin
                            rq_push = go;
                        end
                    end
                    CMD_WRITE_ACQUIRE: begin
                        if (write_free) begin
                            out_granted = 1'b1;
                            out_id      = id_reg;
                            out_write   = 1'b1;
                        end else if (wq_full) begin
                            out_err = 1'b1;
                        end else begin
                            wq_push = go;
                        end
                    end
                    CMD_READ_RELEASE: begin
                        if (active_reg == '0) begin
                            out_err = 1'b1;
                        end else if (active_dec == '0 && !writer_active_reg
                                     && wq_count_reg != '0) begin
                            wq_pop_start = go;
                            out_load     = 1'b0;
                        end
                    end
                    CMD_WRITE_RELEASE: begin
                        if (!writer_active_reg) begin
                            out_err = 1'b1;
                        end else if (rq_count_reg != '0) begin
                            rq_flush_start = go;
                            out_load       = 1'b0;
                        end else if (wq_count_reg != '0) begin
                            wq_pop_start = go;
                            out_load     = 1'b0;
                        end
                    end
                    default: begin
                        out_err = 1'b1;
                    end
                endcase
            end
            ST_WGRANT: begin
                out_load    = 1'b1;
                out_granted = 1'b1;
                out_id      = wq_rd_data;
                out_write   = 1'b1;
            end
            ST_RGRANT: begin
                out_load    = out_free;
                out_granted = 1'b1;
                out_id      = rq_rd_data;
                out_last    = (rq_count_reg == CNT_W'(1));
            end
            default: begin
                out_load = 1'b0;
            end
        endcase
    end

    assign rq_wr_en   = rq_push;
    assign rq_wr_addr = rq_head_reg + rq_count_reg[PTR_W-1:0];
    assign rq_wr_data = id_reg;
    assign wq_wr_en   = wq_push;
    assign wq_wr_addr = wq_head_reg + wq_count_reg[PTR_W-1:0];
    assign wq_wr_data = id_reg;
    assign wq_rd_en   = wq_pop_start;
    assign wq_rd_addr = wq_head_reg;
    assign rq_rd_en   = rq_flush_start
                        || ((state_reg == ST_RGRANT) && out_free && rq_count_reg != CNT_W'(1));
    assign rq_rd_addr = rq_flush_start ? rq_head_reg : rq_head_reg + PTR_W'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            rq_head_reg       <= '0;
            rq_count_reg      <= '0;
            wq_head_reg       <= '0;
            wq_count_reg      <= '0;
            active_reg        <= '0;
            writer_active_reg <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg          <= 1'b1;
                m_granted_reg        <= out_granted;
                m_grant_id_reg       <= out_id;
                m_grant_is_write_reg <= out_write;
                m_request_error_reg  <= out_err;
                m_last_reg           <= out_last;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        cmd_reg   <= cmd_t'(s_cmd);
                        id_reg    <= s_requester_id;
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    if (go) begin
                        case (cmd_reg)
                            CMD_READ_ACQUIRE: begin
                                if (read_free && !out_err) begin
                                    active_reg <= active_reg + CNT_W'(1);
                                end else if (rq_push) begin
                                    rq_count_reg <= rq_count_reg + CNT_W'(1);
                                end
                            end
                            CMD_WRITE_ACQUIRE: begin
                                if (write_free) begin
                                    writer_active_reg <= 1'b1;
                                end else if (wq_push) begin
                                    wq_count_reg <= wq_count_reg + CNT_W'(1);
                                end
                            end
                            CMD_READ_RELEASE: begin
                                if (!out_err) begin
                                    active_reg <= active_dec;
                                end
                            end
                            CMD_WRITE_RELEASE: begin
                                if (!out_err) begin
                                    writer_active_reg <= 1'b0;
                                end
                            end
                            default: begin
                            end
                        endcase
                        if (wq_pop_start) begin
                            state_reg <= ST_WGRANT;
                        end else if (rq_flush_start) begin
                            state_reg <= ST_RGRANT;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_WGRANT: begin
                    writer_active_reg <= 1'b1;
                    wq_head_reg       <= wq_head_reg + PTR_W'(1);
                    wq_count_reg      <= wq_count_reg - CNT_W'(1);
                    state_reg         <= ST_IDLE;
                end
                ST_RGRANT: begin
                    if (out_free) begin
                        rq_head_reg  <= rq_head_reg + PTR_W'(1);
                        rq_count_reg <= rq_count_reg - CNT_W'(1);
                        active_reg   <= active_sat_inc;
                        if (rq_count_reg == CNT_W'(1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_granted        = m_granted_reg;
    assign m_grant_id       = m_grant_id_reg;
    assign m_grant_is_write = m_grant_is_write_reg;
    assign m_request_error  = m_request_error_reg;
    assign m_last           = m_last_reg;

endmodule

/* src/reader_writer_lock_arbiter.sv */
// ----------------------------------------------------------------------------
// Reader/writer lock arbiter
// An item is held in the command register when it is accepted and is then
// decided into the output register; a queued writer is granted through the
// registered read of the writer queue memory. A write release that flushes
// the reader queue first reads the reader queue memory and then emits one
// read grant per cycle while the result side keeps up. The decision waits
// while the output register holds a result item that has not been taken.
// The arbiter takes a new item the cycle after the previous one has been
// decided in full, so it holds one item at a time; waiting readers and
// writers are held in two 64-entry queue memories.
// ----------------------------------------------------------------------------
module reader_writer_lock_arbiter (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [rwla_pkg::CMD_W-1:0] s_cmd,
    input  logic [rwla_pkg::ID_W-1:0]  s_requester_id,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_granted,
    output logic [rwla_pkg::ID_W-1:0]  m_grant_id,
    output logic                       m_grant_is_write,
    output logic                       m_request_error,
    output logic                       m_last
);

    import rwla_pkg::*;

    logic             rq_wr_en;
    logic [PTR_W-1:0] rq_wr_addr;
    logic [ID_W-1:0]  rq_wr_data;
    logic             rq_rd_en;
    logic [PTR_W-1:0] rq_rd_addr;
    logic [ID_W-1:0]  rq_rd_data;
    logic             wq_wr_en;
    logic [PTR_W-1:0] wq_wr_addr;
    logic [ID_W-1:0]  wq_wr_data;
    logic             wq_rd_en;
    logic [PTR_W-1:0] wq_rd_addr;
    logic [ID_W-1:0]  wq_rd_data;

    rwla_core u_core (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_requester_id   (s_requester_id),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_granted        (m_granted),
        .m_grant_id       (m_grant_id),
        .m_grant_is_write (m_grant_is_write),
        .m_request_error  (m_request_error),
        .m_last           (m_last),
        .rq_wr_en         (rq_wr_en),
        .rq_wr_addr       (rq_wr_addr),
        .rq_wr_data       (rq_wr_data),
        .rq_rd_en         (rq_rd_en),
        .rq_rd_addr       (rq_rd_addr),
        .rq_rd_data       (rq_rd_data),
        .wq_wr_en         (wq_wr_en),
        .wq_wr_addr       (wq_wr_addr),
        .wq_wr_data       (wq_wr_data),
        .wq_rd_en         (wq_rd_en),
        .wq_rd_addr       (wq_rd_addr),
        .wq_rd_data       (wq_rd_data)
    );

    rwla_ram #(
        .WIDTH (ID_W),
        .DEPTH (RING_DEPTH)
    ) u_reader_queue (
        .aclk    (aclk),
        .wr_en   (rq_wr_en),
        .wr_addr (rq_wr_addr),
        .wr_data (rq_wr_data),
        .rd_en   (rq_rd_en),
        .rd_addr (rq_rd_addr),
        .rd_data (rq_rd_data)
    );

    rwla_ram #(
        .WIDTH (ID_W),
        .DEPTH (RING_DEPTH)
    ) u_writer_queue (
        .aclk    (aclk),
        .wr_en   (wq_wr_en),
        .wr_addr (wq_wr_addr),
        .wr_data (wq_wr_data),
        .rd_en   (wq_rd_en),
        .rd_addr (wq_rd_addr),
        .rd_data (wq_rd_data)
    );

endmodule
